@@ sv/normal_texel_renormalize_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for normal_texel_renormalize
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef NORMAL_TEXEL_RENORMALIZE_ASSERT_SVH
`define NORMAL_TEXEL_RENORMALIZE_ASSERT_SVH

`ifndef SYNTHESIS
`define NTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define NTR_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/ntr_pkg.sv @@
// ----------------------------------------------------------------------------
// ntr_pkg
// Shared types and constants of the normal texel renormalizer.
// ----------------------------------------------------------------------------
package ntr_pkg;

  localparam int BYTE_W = 8;
  // Signed component u = 2*b - 255 fits in 9 bits.
  localparam int U_W    = 9;
  // u*u is at most 65025.
  localparam int SQ_W   = 16;
  // Sum of three squares is at most 195075.
  localparam int SUM_W  = 18;

  localparam logic [U_W:0]        COMP_BIAS = 10'd255;
  localparam logic [BYTE_W-1:0]   BYTE_MAX  = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] red_in;
    logic [BYTE_W-1:0] green_in;
    logic [BYTE_W-1:0] blue_in;
    logic [BYTE_W-1:0] alpha_in;
  } in_texel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
  } out_texel_t;

endpackage

@@ sv/ntr_rsqrt_step.sv @@
// ----------------------------------------------------------------------------
// ntr_rsqrt_step
// One bit of the reciprocal square root recurrence: tries bit K of R and
// keeps it when (R + 2^K)^2 * S stays below 2^(2F).
// ----------------------------------------------------------------------------
module ntr_rsqrt_step #(
  parameter int F = 24,
  parameter int K = 23
) (
  input  logic [ntr_pkg::SUM_W-1:0] s_i,
  input  logic [2*F-1:0]            p_i,
  input  logic [F+8:0]              q_i,
  input  logic [F-1:0]              r_i,
  output logic [2*F-1:0]            p_o,
  output logic [F+8:0]              q_o,
  output logic [F-1:0]              r_o
);

  localparam int WP = 2 * F;
  localparam int WQ = F + 9;
  localparam int WC = 2 * F + ntr_pkg::SUM_W - 1;

  // p_i holds R^2*S and q_i holds R*S for the bits decided so far.
  logic [WC-1:0] cand;
  logic [WQ-1:0] s_shift;
  logic [F-1:0]  bit_k;
  logic          fits;

  always_comb begin
    cand = {{(WC-WP){1'b0}}, p_i}
         + ({{(WC-WQ){1'b0}}, q_i} << (K + 1))
         + ({{(WC-ntr_pkg::SUM_W){1'b0}}, s_i} << (2 * K));
    fits    = (cand[WC-1:WP] == '0);
    s_shift = {{(WQ-ntr_pkg::SUM_W){1'b0}}, s_i} << K;
    bit_k   = {{(F-1){1'b0}}, 1'b1} << K;
    p_o     = fits ? cand[WP-1:0]     : p_i;
    q_o     = fits ? (q_i + s_shift)  : q_i;
    r_o     = fits ? (r_i | bit_k)    : r_i;
  end

endmodule

@@ sv/normal_texel_renormalize.sv @@
// ----------------------------------------------------------------------------
// normal_texel_renormalize
// Rescales an RGBA8 tangent-space normal texel to unit length; alpha passes.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | into      | in_valid_i / in_stall_o | ntr_pkg::in_texel_t
//   out     | out of    | out_valid_o / out_stall_i | ntr_pkg::out_texel_t
//
// One texel per cycle while the output does not stall.
// The reciprocal square root takes one result bit per stage, which sets the
// depth: decode/square, sum, RSQRT_FRAC_BITS recurrence stages, scale, encode.
// Reset clears only the stage valid bits.
// A stalled output holds; earlier stages keep moving into empty slots, so an
// input transfer is refused only when every stage is full and the output stalls.
// ----------------------------------------------------------------------------
`include "normal_texel_renormalize_assert.svh"

module normal_texel_renormalize #(
  parameter int RSQRT_FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ntr_pkg::in_texel_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ntr_pkg::out_texel_t out_data_o
);

  localparam int F   = RSQRT_FRAC_BITS;
  localparam int NS  = F + 4;
  localparam int WP  = 2 * F;
  localparam int WQ  = F + 9;
  localparam int WT  = F + 10;
  localparam int WV  = WT + ntr_pkg::BYTE_W;
  localparam int U_W = ntr_pkg::U_W;

  // Pipeline positions.
  localparam int ST_SUM   = 1;
  localparam int ST_SCALE = F + 2;
  localparam int ST_OUT   = F + 3;

  logic [NS-1:0] vld_q, vld_d, en;

  // Side data that travels with every stage.
  logic [2:0][U_W-1:0]            u_q [NS];
  logic [ntr_pkg::BYTE_W-1:0]     a_q [NS];

  logic [2:0][U_W-1:0]            u_dec;
  logic [2:0][ntr_pkg::SQ_W-1:0]  sq_d, sq_q;

  logic [ntr_pkg::SUM_W-1:0]      it_s [F+1];
  logic [WP-1:0]                  it_p [F+1];
  logic [WQ-1:0]                  it_q [F+1];
  logic [F-1:0]                   it_r [F+1];

  logic signed [2:0][WT-1:0]      t_d, t_q;
  ntr_pkg::out_texel_t            out_d, out_q;

  // --------------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  assign en[NS-1] = !vld_q[NS-1] || !out_stall_i;
  for (genvar j = 0; j < NS - 1; j++) begin : g_en
    assign en[j] = !vld_q[j] || en[j+1];
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int j = 1; j < NS; j++) begin
      vld_d[j] = en[j] ? vld_q[j-1] : vld_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[ST_OUT];
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Stage 0: byte to signed odd component, and its square.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [U_W:0]            wide;
    logic [ntr_pkg::BYTE_W-1:0] b;
    logic signed [2*U_W-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      case (c)
        0:       b = in_data_i.red_in;
        1:       b = in_data_i.green_in;
        default: b = in_data_i.blue_in;
      endcase
      wide     = {1'b0, b, 1'b0} - ntr_pkg::COMP_BIAS;
      u_dec[c] = wide[U_W-1:0];
      prod     = $signed({{U_W{u_dec[c][U_W-1]}}, u_dec[c]})
               * $signed({{U_W{u_dec[c][U_W-1]}}, u_dec[c]});
      sq_d[c]  = prod[ntr_pkg::SQ_W-1:0];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[0]) begin
          u_q[0] <= u_dec;
          a_q[0] <= in_data_i.alpha_in;
          sq_q   <= sq_d;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          u_q[j] <= u_q[j-1];
          a_q[j] <= a_q[j-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sum of squares. The sum is odd, so it is never zero and the
  // straight-up fallback of a zero-length vector needs no hardware.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      it_s[0] <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
      it_p[0] <= '0;
      it_q[0] <= '0;
      it_r[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Recurrence stages: R = largest r with r^2 * S < 2^(2F), one bit each.
  // --------------------------------------------------------------------------
  for (genvar j = 1; j <= F; j++) begin : g_rsqrt
    logic [WP-1:0] p_nx;
    logic [WQ-1:0] q_nx;
    logic [F-1:0]  r_nx;

    ntr_rsqrt_step #(
      .F (F),
      .K (F - j)
    ) u_step (
      .s_i (it_s[j-1]),
      .p_i (it_p[j-1]),
      .q_i (it_q[j-1]),
      .r_i (it_r[j-1]),
      .p_o (p_nx),
      .q_o (q_nx),
      .r_o (r_nx)
    );

    always_ff @(posedge clk_i) begin
      if (en[ST_SUM+j]) begin
        it_s[j] <= it_s[j-1];
        it_p[j] <= p_nx;
        it_q[j] <= q_nx;
        it_r[j] <= r_nx;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale: t = u*R + 2^F, which is 2^F * (n + 1).
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [WT-1:0] prod;
    logic signed [WT-1:0] one_f;
    logic [U_W-1:0]       u_c;
    one_f = $signed({{(WT-F-1){1'b0}}, 1'b1, {F{1'b0}}});
    for (int c = 0; c < 3; c++) begin
      u_c    = u_q[ST_SCALE-1][c];
      prod   = $signed({{(WT-U_W){u_c[U_W-1]}}, u_c})
             * $signed({{(WT-F){1'b0}}, it_r[F]});
      t_d[c] = prod + one_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SCALE]) begin
      t_q <= t_d;
    end
  end

  // --------------------------------------------------------------------------
  // Encode: (255*t + 2^F) >> (F+1), i.e. round-half-up of 127.5*(n+1),
  // with negative t taken as zero and the byte clamped at 255.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [WT-1:0]          tc;
    logic [WV-1:0]          v;
    logic [WV-F-2:0]        qv;
    logic [ntr_pkg::BYTE_W-1:0] byte_v;
    out_d = '0;
    for (int c = 0; c < 3; c++) begin
      tc = t_q[c][WT-1] ? '0 : t_q[c];
      v  = {tc, {ntr_pkg::BYTE_W{1'b0}}} - {{ntr_pkg::BYTE_W{1'b0}}, tc}
         + {{(WV-F-1){1'b0}}, 1'b1, {F{1'b0}}};
      qv = v[WV-1:F+1];
      if (qv > {{(WV-F-1-ntr_pkg::BYTE_W){1'b0}}, ntr_pkg::BYTE_MAX}) begin
        byte_v = ntr_pkg::BYTE_MAX;
      end else begin
        byte_v = qv[ntr_pkg::BYTE_W-1:0];
      end
      case (c)
        0:       out_d.red_out   = byte_v;
        1:       out_d.green_out = byte_v;
        default: out_d.blue_out  = byte_v;
      endcase
    end
    out_d.alpha_out = a_q[ST_OUT-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NTR_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, in_stall_o,
                   (&vld_q) && out_stall_i, "input refused while a stage is free")
  `NTR_ASSERT_IMPL(a_rsqrt_nonzero, clk_i, rst_ni, vld_q[ST_SCALE-1],
                   it_r[F] != '0, "reciprocal square root came out zero")
  `NTR_ASSERT_IMPL(a_sign_kept, clk_i, rst_ni, out_valid_o,
                   (out_q.red_out[7] != u_q[ST_OUT][0][U_W-1])
                   && (out_q.green_out[7] != u_q[ST_OUT][1][U_W-1])
                   && (out_q.blue_out[7] != u_q[ST_OUT][2][U_W-1]),
                   "component sign lost in renormalization")

endmodule
